[src/mqtt_chk_pkg.sv]
// Package for the MQTT packet stream checker: phase codes, byte roles,
// string kinds, error codes and packet type codes. No dependencies.
package mqtt_chk_pkg;

	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_LEN     = 4'd1,
		PH_SKIP    = 4'd2,
		PH_ID_HI   = 4'd3,
		PH_ID_LO   = 4'd4,
		PH_SLEN_HI = 4'd5,
		PH_SLEN_LO = 4'd6,
		PH_SBODY   = 4'd7,
		PH_QOS     = 4'd8,
		PH_CODE    = 4'd9,
		PH_LEVEL   = 4'd10,
		PH_CFLAGS  = 4'd11,
		PH_KEEP_HI = 4'd12,
		PH_KEEP_LO = 4'd13,
		PH_PAYLOAD = 4'd14,
		PH_DONE    = 4'd15
	} phase_t;

	localparam logic [3:0] ROLE_HDR     = 4'd0;
	localparam logic [3:0] ROLE_LEN     = 4'd1;
	localparam logic [3:0] ROLE_ID      = 4'd2;
	localparam logic [3:0] ROLE_SLEN    = 4'd3;
	localparam logic [3:0] ROLE_SBYTE   = 4'd4;
	localparam logic [3:0] ROLE_PAYLOAD = 4'd5;
	localparam logic [3:0] ROLE_QOS     = 4'd6;
	localparam logic [3:0] ROLE_CODE    = 4'd7;
	localparam logic [3:0] ROLE_CONNECT = 4'd8;
	localparam logic [3:0] ROLE_DISCARD = 4'd9;

	localparam logic [2:0] SK_TOPIC    = 3'd1;
	localparam logic [2:0] SK_NAME     = 3'd2;
	localparam logic [2:0] SK_CLIENT   = 3'd3;
	localparam logic [2:0] SK_WTOPIC   = 3'd4;
	localparam logic [2:0] SK_WPAYLOAD = 3'd5;
	localparam logic [2:0] SK_USER     = 3'd6;
	localparam logic [2:0] SK_PASS     = 3'd7;

	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_TYPE     = 4'd1;
	localparam logic [3:0] ERR_FLAGS    = 4'd2;
	localparam logic [3:0] ERR_LEN_LONG = 4'd3;
	localparam logic [3:0] ERR_LEN      = 4'd4;
	localparam logic [3:0] ERR_OVERRUN  = 4'd5;
	localparam logic [3:0] ERR_EMPTY    = 4'd6;
	localparam logic [3:0] ERR_ID_ZERO  = 4'd7;
	localparam logic [3:0] ERR_CODE     = 4'd8;
	localparam logic [3:0] ERR_CONNACK  = 4'd9;
	localparam logic [3:0] ERR_NAME     = 4'd10;
	localparam logic [3:0] ERR_LEVEL    = 4'd11;
	localparam logic [3:0] ERR_CFLAGS   = 4'd12;
	localparam logic [3:0] ERR_CLIENT   = 4'd13;
	localparam logic [3:0] ERR_MISSING  = 4'd14;
	localparam logic [3:0] ERR_TRAILING = 4'd15;

	localparam logic [3:0] T_CONNECT   = 4'd1;
	localparam logic [3:0] T_CONNACK   = 4'd2;
	localparam logic [3:0] T_PUBLISH   = 4'd3;
	localparam logic [3:0] T_SUBSCRIBE = 4'd8;
	localparam logic [3:0] T_SUBACK    = 4'd9;
	localparam logic [3:0] T_UNSUB     = 4'd10;

	// "MQTT"
	function automatic logic [7:0] proto_char(input logic [1:0] idx);
		case (idx)
			2'd0:    proto_char = 8'h4D;
			2'd1:    proto_char = 8'h51;
			default: proto_char = 8'h54;
		endcase
	endfunction

endpackage

[src/mqtt_packet_stream_checker_core.sv]
// Top level of the MQTT 3.1.1 packet stream checker.
// Depends on mqtt_chk_pkg.
//
// Usage:
//  - Input channel: rx_byte with in_valid / in_ready, one stream word per beat.
//  - Output channel: one result word per input word (data_byte, byte_role,
//    string_kind, packet_type, packet_ident, qos_level, dup_flag,
//    retain_flag, error_code, packet_end, packet_ok) with out_valid/out_ready.
//  - out_valid rises in the cycle after acceptance. Throughput: one word
//    per cycle while out_ready is high; the decode step for a word is one
//    combinational pass from the parser state registers to the output register.
//  - Stall: in_ready follows out_ready or an empty output register, so the
//    block takes a new word in the cycle the held result is taken.
//  - Reset (arst_n low) clears the parser to await a fixed header and
//    empties the output register. A bad type, bad header flags or an
//    over-long length halt the parser until reset; afterwards every word
//    comes back as discarded with all decoded fields zero.
//  - A content error is flagged on the word where it is found and the rest
//    of the packet is discarded; packet_end marks each packet's last word.
module mqtt_packet_stream_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic [3:0]  byte_role,
	output logic [2:0]  string_kind,
	output logic [3:0]  packet_type,
	output logic [15:0] packet_ident,
	output logic [1:0]  qos_level,
	output logic        dup_flag,
	output logic        retain_flag,
	output logic [3:0]  error_code,
	output logic        packet_end,
	output logic        packet_ok
);
	import mqtt_chk_pkg::*;

	// parser state
	phase_t      phase_q;
	logic [3:0]  kind_q, flags_q;
	logic [27:0] lenval_q, left_q;
	logic [2:0]  lencnt_q;
	logic [15:0] sleft_q, ident_q;
	logic [3:0]  step_q;
	logic [7:0]  cflag_q;
	logic        bad_q, halted_q;

	phase_t      phase_d;
	logic [3:0]  kind_d, flags_d, step_d;
	logic [27:0] lenval_d, left_d;
	logic [2:0]  lencnt_d;
	logic [15:0] sleft_d, ident_d;
	logic [7:0]  cflag_d;
	logic        bad_d, halted_d;

	// result word being formed
	logic [3:0] role, err, ptype, pf;
	logic [2:0] sk;
	logic       pend, pok, finish;
	logic [15:0] n;
	logic       ns_on5, ns_on6, ns_on8, ns_on9;
	logic [3:0] ns_from;
	logic [27:0] shifted;
	logic       accept;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	function automatic logic [2:0] str_kind(input logic [3:0] k, input logic [3:0] s);
		if (k != T_CONNECT) str_kind = SK_TOPIC;
		else begin
			case (s)
				4'd0:    str_kind = SK_NAME;
				4'd5:    str_kind = SK_CLIENT;
				4'd6:    str_kind = SK_WTOPIC;
				4'd7:    str_kind = SK_WPAYLOAD;
				4'd8:    str_kind = SK_USER;
				default: str_kind = SK_PASS;
			endcase
		end
	endfunction

	function automatic logic len_wrong(input logic [3:0] k, input logic [27:0] rl);
		case (k)
			4'd1:                             len_wrong = rl < 28'd12;
			4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd11: len_wrong = rl != 28'd2;
			4'd8:                             len_wrong = rl < 28'd6;
			4'd9:                             len_wrong = rl < 28'd3;
			4'd10:                            len_wrong = rl < 28'd5;
			4'd3:                             len_wrong = 1'b0;
			default:                          len_wrong = rl != 28'd0;
		endcase
	endfunction

	always_comb begin
		phase_d  = phase_q;  kind_d  = kind_q;  flags_d = flags_q;
		lenval_d = lenval_q; left_d  = left_q;  lencnt_d = lencnt_q;
		sleft_d  = sleft_q;  ident_d = ident_q; step_d  = step_q;
		cflag_d  = cflag_q;  bad_d   = bad_q;   halted_d = halted_q;
		role = ROLE_DISCARD; sk = 3'd0; err = ERR_NONE; ptype = 4'd0; pf = 4'd0;
		pend = 1'b0; pok = 1'b0; finish = 1'b0;
		n = sleft_q | {8'd0, rx_byte};
		shifted = 28'd0;
		ns_from = 4'd5;
		ns_on5 = 1'b0; ns_on6 = 1'b0; ns_on8 = 1'b0; ns_on9 = 1'b0;

		if (halted_q) begin
			role = ROLE_DISCARD;
		end else if (phase_q == PH_HDR) begin
			role = ROLE_HDR;
			ident_d = 16'd0;
			ptype = rx_byte[7:4];
			if (rx_byte[7:4] == 4'd0 || rx_byte[7:4] == 4'd15) err = ERR_TYPE;
			else if (rx_byte[7:4] == T_PUBLISH) begin
				if (rx_byte[2:1] == 2'd3) err = ERR_FLAGS;
			end else if (rx_byte[7:4] == 4'd6 || rx_byte[7:4] == T_SUBSCRIBE ||
				rx_byte[7:4] == T_UNSUB) begin
				if (rx_byte[3:0] != 4'h2) err = ERR_FLAGS;
			end else if (rx_byte[3:0] != 4'd0) err = ERR_FLAGS;
			if (err != ERR_NONE) halted_d = 1'b1;
			else begin
				kind_d = rx_byte[7:4]; flags_d = rx_byte[3:0];
				lenval_d = '0; lencnt_d = '0; left_d = '0; sleft_d = '0;
				step_d = '0; cflag_d = '0; bad_d = 1'b0;
				phase_d = PH_LEN;
				pf = rx_byte[3:0];
			end
		end else if (phase_q == PH_LEN) begin
			role = ROLE_LEN;
			ptype = kind_q; pf = flags_q;
			case (lencnt_q[1:0])
				2'd0:    shifted = {21'd0, rx_byte[6:0]};
				2'd1:    shifted = {14'd0, rx_byte[6:0], 7'd0};
				2'd2:    shifted = {7'd0, rx_byte[6:0], 14'd0};
				default: shifted = {rx_byte[6:0], 21'd0};
			endcase
			lenval_d = lenval_q | shifted;
			lencnt_d = lencnt_q + 3'd1;
			if (rx_byte[7]) begin
				if (lencnt_d >= 3'd4) begin
					err = ERR_LEN_LONG; halted_d = 1'b1; pf = 4'd0;
				end
			end else begin
				left_d = lenval_d;
				step_d = 4'd0;
				if (len_wrong(kind_q, lenval_d)) err = ERR_LEN;
				else if (kind_q == T_CONNECT || kind_q == T_PUBLISH) phase_d = PH_SLEN_HI;
				else if (kind_q == T_CONNACK) phase_d = PH_CODE;
				else if (kind_q >= 4'd4 && kind_q <= 4'd11) phase_d = PH_ID_HI;
				else phase_d = PH_DONE;
				finish = 1'b1;
			end
		end else begin
			ptype = kind_q; pf = flags_q;
			if (left_q != 28'd0) left_d = left_q - 28'd1;
			finish = 1'b1;
			case (phase_q)
				PH_ID_HI: begin
					role = ROLE_ID; sleft_d = {rx_byte, 8'd0}; phase_d = PH_ID_LO;
				end
				PH_ID_LO: begin
					role = ROLE_ID; ident_d = n;
					if (n == 16'd0) err = ERR_ID_ZERO;
					else begin
						step_d = 4'd0;
						if (kind_q == T_PUBLISH) phase_d = PH_PAYLOAD;
						else if (kind_q == T_SUBSCRIBE || kind_q == T_UNSUB)
							phase_d = PH_SLEN_HI;
						else if (kind_q == T_SUBACK) phase_d = PH_CODE;
						else phase_d = PH_DONE;
					end
				end
				PH_SLEN_HI: begin
					role = ROLE_SLEN; sk = str_kind(kind_q, step_q);
					sleft_d = {rx_byte, 8'd0}; phase_d = PH_SLEN_LO;
				end
				PH_SLEN_LO: begin
					role = ROLE_SLEN; sk = str_kind(kind_q, step_q);
					if ({12'd0, n} > left_d) err = ERR_OVERRUN;
					else if ((kind_q == T_PUBLISH || kind_q == T_SUBSCRIBE ||
						kind_q == T_UNSUB || (kind_q == T_CONNECT && step_q == 4'd6)) &&
						n == 16'd0) err = ERR_EMPTY;
					else if (kind_q == T_CONNECT && step_q == 4'd0 && n != 16'd4)
						err = ERR_NAME;
					else if (kind_q == T_CONNECT && step_q == 4'd5 && n == 16'd0 &&
						!cflag_q[1]) err = ERR_CLIENT;
					else begin
						sleft_d = n;
						phase_d = PH_SBODY;
					end
				end
				PH_SBODY: begin
					role = ROLE_SBYTE; sk = str_kind(kind_q, step_q);
					if (kind_q == T_CONNECT && step_q == 4'd0 &&
						rx_byte != proto_char(2'(3'd4 - sleft_q[2:0])))
						err = ERR_NAME;
					sleft_d = sleft_q - 16'd1;
				end
				PH_QOS: begin
					role = ROLE_QOS;
					if (rx_byte > 8'd2) err = ERR_CODE;
					else begin phase_d = PH_SLEN_HI; step_d = 4'd0; end
				end
				PH_CODE: begin
					role = ROLE_CODE;
					if (kind_q == T_CONNACK) begin
						if (step_q == 4'd0) begin
							if ((rx_byte & 8'hFE) != 8'd0) err = ERR_CONNACK;
							else step_d = 4'd1;
						end else begin
							if (rx_byte > 8'd5) err = ERR_CODE;
							else phase_d = PH_DONE;
						end
					end else if (rx_byte > 8'd2 && rx_byte != 8'h80) err = ERR_CODE;
				end
				PH_LEVEL: begin
					role = ROLE_CONNECT;
					if (rx_byte != 8'h04) err = ERR_LEVEL; else phase_d = PH_CFLAGS;
				end
				PH_CFLAGS: begin
					role = ROLE_CONNECT; cflag_d = rx_byte;
					if (rx_byte[0] || (!rx_byte[2] && rx_byte[5:3] != 3'd0) ||
						(rx_byte[2] && rx_byte[4:3] == 2'd3) ||
						(rx_byte[6] && !rx_byte[7])) err = ERR_CFLAGS;
					else phase_d = PH_KEEP_HI;
				end
				PH_KEEP_HI: begin
					role = ROLE_CONNECT; phase_d = PH_KEEP_LO;
				end
				PH_KEEP_LO: begin
					role = ROLE_CONNECT;
				end
				PH_PAYLOAD: role = ROLE_PAYLOAD;
				PH_DONE: begin
					role = ROLE_DISCARD; err = ERR_TRAILING;
				end
				default: begin
					role = ROLE_DISCARD; bad_d = 1'b1; phase_d = PH_SKIP;
				end
			endcase

			// end of a string: zero length after prefix, or last body byte
			if (err == ERR_NONE &&
				((phase_q == PH_SLEN_LO && n == 16'd0) ||
				(phase_q == PH_SBODY && sleft_d == 16'd0))) begin
				if (kind_q == T_CONNECT) begin
					if (step_q == 4'd0) phase_d = PH_LEVEL;
					else ns_from = step_q + 4'd1;
				end else if (kind_q == T_PUBLISH)
					phase_d = (flags_q[2:1] != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
				else if (kind_q == T_SUBSCRIBE) phase_d = PH_QOS;
				else phase_d = PH_SLEN_HI;
			end
			// next optional CONNECT string, from step ns_from
			if ((phase_q == PH_KEEP_LO) || (err == ERR_NONE && kind_q == T_CONNECT &&
				step_q != 4'd0 && ((phase_q == PH_SLEN_LO && n == 16'd0) ||
				(phase_q == PH_SBODY && sleft_d == 16'd0)))) begin
				ns_on5 = ns_from <= 4'd5;
				ns_on6 = ns_from <= 4'd7 && cflag_d[2];
				ns_on8 = ns_from <= 4'd8 && cflag_d[7];
				ns_on9 = ns_from <= 4'd9 && cflag_d[6];
				phase_d = PH_SLEN_HI;
				if (ns_on5) step_d = 4'd5;
				else if (ns_on6) step_d = (ns_from <= 4'd6) ? 4'd6 : 4'd7;
				else if (ns_on8) step_d = 4'd8;
				else if (ns_on9) step_d = 4'd9;
				else phase_d = PH_DONE;
			end
		end

		if (finish) begin
			if (err == ERR_NONE && left_d == 28'd0 && phase_d != PH_SKIP) begin
				if (phase_d == PH_PAYLOAD || phase_d == PH_DONE) err = ERR_NONE;
				else if (phase_d == PH_CODE && kind_d == T_SUBACK) err = ERR_NONE;
				else if (phase_d == PH_SLEN_HI &&
					(kind_d == T_SUBSCRIBE || kind_d == T_UNSUB)) err = ERR_NONE;
				else if (phase_d == PH_SLEN_HI || phase_d == PH_SLEN_LO ||
					phase_d == PH_SBODY) err = ERR_OVERRUN;
				else err = ERR_MISSING;
			end
			if (err != ERR_NONE) bad_d = 1'b1;
			if (left_d == 28'd0) begin
				pend = 1'b1; pok = !bad_d; phase_d = PH_HDR; bad_d = 1'b0;
			end else if (err != ERR_NONE) phase_d = PH_SKIP;
		end
	end

	// hold parser state; advance only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR; kind_q <= '0; flags_q <= '0; lenval_q <= '0;
			left_q <= '0; lencnt_q <= '0; sleft_q <= '0; ident_q <= '0;
			step_q <= '0; cflag_q <= '0; bad_q <= 1'b0; halted_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d; kind_q <= kind_d; flags_q <= flags_d;
			lenval_q <= lenval_d; left_q <= left_d; lencnt_q <= lencnt_d;
			sleft_q <= sleft_d; ident_q <= ident_d; step_q <= step_d;
			cflag_q <= cflag_d; bad_q <= bad_d; halted_q <= halted_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (accept) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	// result register: load on accept, hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte    <= rx_byte;
			byte_role    <= role;
			string_kind  <= sk;
			packet_type  <= ptype;
			packet_ident <= halted_q ? 16'd0 : ident_d;
			qos_level    <= (ptype == T_PUBLISH) ? pf[2:1] : 2'd0;
			dup_flag     <= (ptype == T_PUBLISH) && pf[3];
			retain_flag  <= (ptype == T_PUBLISH) && pf[0];
			error_code   <= err;
			packet_end   <= pend;
			packet_ok    <= pok;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt flag cleared without reset");
	a_ok_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_ok |-> packet_end && error_code == ERR_NONE)
		else $error("packet_ok off packet end");
	a_halt_out: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept) && $past(halted_q) |-> byte_role == ROLE_DISCARD && !packet_end)
		else $error("halted word not discarded");
endmodule
